// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define SFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define SFA_ASSERT_RESET(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sfa_pkg.sv =====
// Types and constants of the spring force accumulator.
package sfa_pkg;

  localparam int unsigned IDX_W     = 10;
  localparam int unsigned COMP_W    = 32;
  localparam int unsigned MAG_W     = 33;
  localparam int unsigned SUM_W     = 66;
  localparam int unsigned ROOT_W    = 33;
  localparam int unsigned PROD_W    = 66;
  localparam int unsigned NUM_W     = 98;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DEN_W     = ROOT_W + FRAC_W;
  localparam int unsigned QUO_W     = 33;
  localparam int unsigned NUM_LANES = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [COMP_W-1:0] STIFF_RST = 32'd65536;
  localparam logic [COMP_W-1:0] REST_RST  = 32'd65536;

  typedef enum logic [1:0] {
    OP_WRPOS  = 2'd0,
    OP_SPRING = 2'd1,
    OP_SETF   = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STIFF = 1'b0,
    REG_REST  = 1'b1
  } reg_e;

  typedef logic [NUM_LANES-1:0][COMP_W-1:0] vec_t;

  typedef struct packed {
    op_e                      opcode;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         second_index;
    logic signed [COMP_W-1:0] value_x;
    logic signed [COMP_W-1:0] value_y;
    logic signed [COMP_W-1:0] value_z;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         result_index;
    logic signed [COMP_W-1:0] force_x;
    logic signed [COMP_W-1:0] force_y;
    logic signed [COMP_W-1:0] force_z;
    logic                     saturated;
  } out_t;

endpackage

// ===== rtl/spring_force_accumulator_top.sv =====
// Spring force accumulator: position and force memories with a spring datapath.
//
// Input channel in_valid_i/in_ready_o/in_i carries one operation per item:
// write position, apply spring, set force or read force. Output channel
// out_valid_o/out_ready_i/out_o returns exactly one result item per input.
// The block works on one item at a time; in_ready_o is high only while idle.
// Write position and set force write their memory on accept; read force reads
// the force memory. Apply spring reads both positions, sums the squared
// differences, takes the square root (a zero distance ends the item there),
// forms products with stiffness on the shared multiplier, divides in the
// three-lane divider and read-modify-writes the force of both endpoints in
// turn. The next item can be taken in the same cycle the result turns valid.
// A finished result sits in the output register until taken. While the receiver
// stalls, the block may take the next item, then holds that result in the final
// state and accepts no item until the old one is taken. Reset clears the
// control state and loads stiffness and rest length with 1.0; memory contents
// are undefined until written. Configuration: cfg_we_i writes cfg_wdata_i to
// register cfg_idx_i only while idle; the user, not the block, enforces this.
module spring_force_accumulator_top #(
  parameter int unsigned PARTICLE_COUNT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfa_pkg::COMP_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  sfa_pkg::in_t                   in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output sfa_pkg::out_t                  out_o
);
  import sfa_pkg::*;

  localparam int unsigned AW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_READ = 11'b00000000010,
    S_PA   = 11'b00000000100,
    S_PB   = 11'b00000001000,
    S_SQ   = 11'b00000010000,
    S_ROOT = 11'b00000100000,
    S_PROD = 11'b00001000000,
    S_DIV  = 11'b00010000000,
    S_FA   = 11'b00100000000,
    S_FB   = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_e;

  function automatic logic [COMP_W:0] clip33(input logic [COMP_W:0] s);
    logic [COMP_W:0] r;
    if (s[COMP_W] != s[COMP_W-1]) begin
      r = {1'b1, s[COMP_W], {(COMP_W-1){~s[COMP_W]}}};
    end else begin
      r = {1'b0, s[COMP_W-1:0]};
    end
    return r;
  endfunction

  state_e                          state_q, state_d;
  in_t                             item_q, item_d;
  logic [COMP_W-1:0]               stiff_q, rest_q;
  vec_t                            pa_q, pa_d;
  logic [NUM_LANES-1:0][MAG_W-1:0] mag_q, mag_d;
  logic [NUM_LANES-1:0]            dneg_q, dneg_d;
  logic [SUM_W-1:0]                sum_q, sum_d;
  logic [3:0]                      cnt_q, cnt_d;
  logic [ROOT_W-1:0]               dist_q, dist_d;
  logic [MAG_W-1:0]                extm_q, extm_d;
  logic                            eneg_q, eneg_d;
  logic [PROD_W-1:0]               prod_q;
  logic [MAG_W-1:0]                phi_q, phi_d;
  logic [PROD_W-2:0]               acc_q, acc_d;
  logic [NUM_LANES-1:0][NUM_W-1:0] num_q, num_d;
  vec_t                            f_q, f_d;
  logic                            sat_q, sat_d;
  out_t                            out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  vec_t              pos_mem [PARTICLE_COUNT];
  vec_t              force_mem [PARTICLE_COUNT];
  vec_t              pos_rd_q, force_rd_q;
  logic              pos_we, force_we;
  logic [AW-1:0]     pos_waddr, pos_raddr, force_waddr, force_raddr;
  vec_t              pos_wdata, force_wdata;

  logic              accept;
  logic              a_ok_in, b_ok_in, a_ok_q;
  vec_t              in_vec;
  logic [1:0]        lane_sel;
  logic [MAG_W-1:0]  mag_sel;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;
  logic              div_start, div_done;
  logic [NUM_LANES-1:0][QUO_W-1:0] div_quo;
  logic [NUM_LANES-1:0]            div_big;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign a_ok_in    = 32'(in_i.first_index) < 32'(PARTICLE_COUNT);
  assign b_ok_in    = 32'(in_i.second_index) < 32'(PARTICLE_COUNT);
  assign a_ok_q     = 32'(item_q.first_index) < 32'(PARTICLE_COUNT);
  assign in_vec     = {in_i.value_z, in_i.value_y, in_i.value_x};
  assign lane_sel   = (state_q == S_SQ) ? cnt_q[1:0] : cnt_q[3:2];

  always_comb begin
    case (lane_sel)
      2'd0:    mag_sel = mag_q[0];
      2'd1:    mag_sel = mag_q[1];
      default: mag_sel = mag_q[2];
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_SQ) begin
      mul_a = mag_sel;
      mul_b = mag_sel;
    end else if (state_q == S_PROD) begin
      case (cnt_q[1:0])
        2'd0: begin
          mul_a = mag_sel;
          mul_b = extm_q;
        end
        2'd1: begin
          mul_a = prod_q[MAG_W-1:0];
          mul_b = {1'b0, stiff_q};
        end
        2'd2: begin
          mul_a = phi_q;
          mul_b = {1'b0, stiff_q};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    pos_we    = accept && (in_i.opcode == OP_WRPOS) && a_ok_in;
    pos_waddr = AW'(in_i.first_index);
    pos_wdata = in_vec;
    pos_raddr = (state_q == S_PA) ? AW'(item_q.second_index) : AW'(in_i.first_index);
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (force_we) begin
      force_mem[force_waddr] <= force_wdata;
    end
    force_rd_q <= force_mem[force_raddr];
  end

  always_comb begin
    logic [COMP_W:0]  s;
    logic [COMP_W:0]  c;
    logic [MAG_W-1:0] diff;
    logic [ROOT_W:0]  ext;
    logic [QUO_W-1:0] q;
    logic             neg;
    state_d     = state_q;
    item_d      = item_q;
    pa_d        = pa_q;
    mag_d       = mag_q;
    dneg_d      = dneg_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    dist_d      = dist_q;
    extm_d      = extm_q;
    eneg_d      = eneg_q;
    phi_d       = phi_q;
    acc_d       = acc_q;
    num_d       = num_q;
    f_d         = f_q;
    sat_d       = sat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    force_we    = 1'b0;
    force_waddr = AW'(item_q.first_index);
    force_wdata = in_vec;
    force_raddr = AW'(item_q.first_index);
    sqrt_start  = 1'b0;
    div_start   = 1'b0;
    s           = '0;
    c           = '0;
    diff        = '0;
    ext         = '0;
    q           = '0;
    neg         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        force_raddr = AW'(in_i.first_index);
        if (accept) begin
          item_d = in_i;
          f_d    = '0;
          sat_d  = 1'b0;
          case (in_i.opcode)
            OP_WRPOS: state_d = S_DONE;
            OP_SETF: begin
              f_d         = in_vec;
              force_we    = a_ok_in;
              force_waddr = AW'(in_i.first_index);
              state_d     = S_DONE;
            end
            OP_READ: state_d = S_READ;
            default: state_d = (a_ok_in && b_ok_in) ? S_PA : S_DONE;
          endcase
        end
      end
      S_READ: begin
        f_d     = a_ok_q ? force_rd_q : '0;
        state_d = S_DONE;
      end
      S_PA: begin
        pa_d    = pos_rd_q;
        state_d = S_PB;
      end
      S_PB: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          diff      = {pos_rd_q[i][COMP_W-1], pos_rd_q[i]} - {pa_q[i][COMP_W-1], pa_q[i]};
          dneg_d[i] = diff[MAG_W-1];
          mag_d[i]  = diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;
        end
        sum_d   = '0;
        cnt_d   = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        if (cnt_q != 4'd0) begin
          sum_d = sum_q + prod_q;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd3) begin
          sqrt_start = 1'b1;
          cnt_d      = '0;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          if (sqrt_root == '0) begin
            state_d = S_DONE;
          end else begin
            ext     = {1'b0, sqrt_root} - {2'b00, rest_q};
            dist_d  = sqrt_root;
            eneg_d  = ext[ROOT_W];
            extm_d  = ext[ROOT_W] ? MAG_W'((ROOT_W + 1)'(0) - ext) : ext[MAG_W-1:0];
            cnt_d   = '0;
            state_d = S_PROD;
          end
        end
      end
      S_PROD: begin
        case (cnt_q[1:0])
          2'd1:    phi_d = prod_q[PROD_W-1:MAG_W];
          2'd2:    acc_d = prod_q[PROD_W-2:0];
          2'd3: begin
            for (int i = 0; i < NUM_LANES; i++) begin
              if (cnt_q[3:2] == 2'(i)) begin
                num_d[i] = NUM_W'(acc_q) + {prod_q[PROD_W-2:0], {MAG_W{1'b0}}};
              end
            end
          end
          default: ;
        endcase
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'd11) begin
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_q == 4'd0) begin
          div_start = 1'b1;
          cnt_d     = 4'd1;
        end else if (div_done) begin
          for (int i = 0; i < NUM_LANES; i++) begin
            q   = div_quo[i];
            neg = dneg_q[i] ^ eneg_q;
            if (div_big[i] || (q > QUO_W'(33'h080000000))) begin
              sat_d  = 1'b1;
              f_d[i] = neg ? 32'h80000000 : 32'h7fffffff;
            end else if (neg) begin
              f_d[i] = COMP_W'(QUO_W'(0) - q);
            end else if (q[COMP_W-1]) begin
              sat_d  = 1'b1;
              f_d[i] = 32'h7fffffff;
            end else begin
              f_d[i] = q[COMP_W-1:0];
            end
          end
          cnt_d   = '0;
          state_d = S_FA;
        end
      end
      S_FA: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          s              = {force_rd_q[i][COMP_W-1], force_rd_q[i]}
                           + {f_q[i][COMP_W-1], f_q[i]};
          c              = clip33(s);
          force_wdata[i] = c[COMP_W-1:0];
          if (c[COMP_W]) begin
            sat_d = 1'b1;
          end
        end
        force_we    = 1'b1;
        force_waddr = AW'(item_q.first_index);
        force_raddr = AW'(item_q.second_index);
        state_d     = S_FB;
      end
      S_FB: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          s              = {force_rd_q[i][COMP_W-1], force_rd_q[i]}
                           - {f_q[i][COMP_W-1], f_q[i]};
          c              = clip33(s);
          force_wdata[i] = c[COMP_W-1:0];
          if (c[COMP_W]) begin
            sat_d = 1'b1;
          end
        end
        force_we    = 1'b1;
        force_waddr = AW'(item_q.second_index);
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.result_index = item_q.first_index;
          out_d.force_x      = f_q[0];
          out_d.force_y      = f_q[1];
          out_d.force_z      = f_q[2];
          out_d.saturated    = sat_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      stiff_q     <= STIFF_RST;
      rest_q      <= REST_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_STIFF: stiff_q <= cfg_wdata_i;
          REG_REST:  rest_q  <= cfg_wdata_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    pa_q   <= pa_d;
    mag_q  <= mag_d;
    dneg_q <= dneg_d;
    sum_q  <= sum_d;
    dist_q <= dist_d;
    extm_q <= extm_d;
    eneg_q <= eneg_d;
    phi_q  <= phi_d;
    acc_q  <= acc_d;
    num_q  <= num_d;
    f_q    <= f_d;
    sat_q  <= sat_d;
    out_q  <= out_d;
  end

  sfa_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_d),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  sfa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   ({dist_q, {FRAC_W{1'b0}}}),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .big_o   (div_big)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/sfa_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
module sfa_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sfa_pkg::SUM_W-1:0]    radicand_i,
  output logic                         done_o,
  output logic [sfa_pkg::ROOT_W-1:0]   root_o
);
  import sfa_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 3;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [SUM_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [REM_W-1:0]  shifted;
  logic [REM_W-1:0]  trial;

  always_comb begin
    shifted = {rem_q[REM_W-3:0], rad_q[SUM_W-1 -: 2]};
    trial   = {1'b0, root_q, 2'b01};
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[SUM_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_d  = shifted - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/sfa_div.sv =====
// Three-lane restoring divider with a shared divisor and overflow flag.
module sfa_div (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                start_i,
  input  logic [sfa_pkg::NUM_LANES-1:0][sfa_pkg::NUM_W-1:0]   num_i,
  input  logic [sfa_pkg::DEN_W-1:0]                           den_i,
  output logic                                                done_o,
  output logic [sfa_pkg::NUM_LANES-1:0][sfa_pkg::QUO_W-1:0]   quo_o,
  output logic [sfa_pkg::NUM_LANES-1:0]                       big_o
);
  import sfa_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);
  localparam int unsigned HI_W  = NUM_W - QUO_W;

  logic [DEN_W-1:0]                    den_q, den_d;
  logic [NUM_LANES-1:0][DEN_W-1:0]     rem_q, rem_d;
  logic [NUM_LANES-1:0][QUO_W-1:0]     lo_q, lo_d;
  logic [NUM_LANES-1:0][QUO_W-1:0]     quo_q, quo_d;
  logic [NUM_LANES-1:0]                big_q, big_d;
  logic [CNT_W-1:0]                    cnt_q, cnt_d;
  logic                                busy_q, busy_d;
  logic                                done_q, done_d;

  always_comb begin
    logic [DEN_W:0] sh;
    den_d  = den_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    big_d  = big_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh     = '0;
    if (start_i) begin
      den_d = den_i;
      for (int i = 0; i < NUM_LANES; i++) begin
        big_d[i] = num_i[i][NUM_W-1:QUO_W] >= HI_W'(den_i);
        rem_d[i] = num_i[i][QUO_W+DEN_W-1:QUO_W];
        lo_d[i]  = num_i[i][QUO_W-1:0];
        quo_d[i] = '0;
      end
      cnt_d  = CNT_W'(QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        sh       = {rem_q[i], lo_q[i][QUO_W-1]};
        lo_d[i]  = {lo_q[i][QUO_W-2:0], 1'b0};
        if (sh >= {1'b0, den_q}) begin
          rem_d[i] = DEN_W'(sh - {1'b0, den_q});
          quo_d[i] = {quo_q[i][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[i] = sh[DEN_W-1:0];
          quo_d[i] = {quo_q[i][QUO_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    big_q <= big_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign big_o  = big_q;

endmodule

// ===== rtl/sfa_checker.sv =====
// Port-level checker for the spring force accumulator and its bind.
`include "assert_macros.svh"

module sfa_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input sfa_pkg::out_t out_o
);
  import sfa_pkg::*;

  `SFA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out item dropped while stalled")
  `SFA_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_o), "out item changed while stalled")
  `SFA_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while busy")
  `SFA_ASSERT(a_no_early, clk_i, rst_ni, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result appeared too early")
  `SFA_ASSERT_RESET(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "out valid during reset")

endmodule

bind spring_force_accumulator_top sfa_checker u_sfa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);
